### rtl/cbp_pkg.sv
// shared types, constants and width-mode decoding for the coefficient bit packer
`default_nettype none
package cbp_pkg;

  localparam int unsigned COEF_W     = 11;
  localparam int unsigned MAX_GROUP  = 8;
  localparam int unsigned GROUP_BITS = COEF_W * MAX_GROUP;
  localparam int unsigned FILL_W     = $clog2(MAX_GROUP);
  localparam int unsigned OFF_W      = $clog2(GROUP_BITS);
  localparam int unsigned NBYTES_W   = 4;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_D4  = 2'd0,
    MODE_D5  = 2'd1,
    MODE_D10 = 2'd2,
    MODE_D11 = 2'd3
  } width_mode_e;

  localparam width_mode_e MODE_RESET = MODE_D11;

  typedef struct packed {
    logic [GROUP_BITS-1:0] bits;
    logic [NBYTES_W-1:0]   nbytes;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [COEF_W-1:0] coef_mask(width_mode_e mode);
    logic [COEF_W-1:0] m;
    unique case (mode)
      MODE_D4:  m = 11'h00F;
      MODE_D5:  m = 11'h01F;
      MODE_D10: m = 11'h3FF;
      default:  m = 11'h7FF;
    endcase
    return m;
  endfunction

  function automatic logic [FILL_W-1:0] last_slot(width_mode_e mode);
    logic [FILL_W-1:0] s;
    if (mode == MODE_D10) begin
      s = FILL_W'(MAX_GROUP / 2 - 1);
    end else begin
      s = FILL_W'(MAX_GROUP - 1);
    end
    return s;
  endfunction

  function automatic logic [NBYTES_W-1:0] burst_len(width_mode_e mode);
    logic [NBYTES_W-1:0] n;
    unique case (mode)
      MODE_D4:  n = 4'd4;
      MODE_D5:  n = 4'd5;
      MODE_D10: n = 4'd5;
      default:  n = 4'd11;
    endcase
    return n;
  endfunction

  function automatic logic [OFF_W-1:0] slot_offset(width_mode_e mode, logic [FILL_W-1:0] slot);
    logic [OFF_W-1:0] s;
    logic [OFF_W-1:0] o;
    s = OFF_W'(slot);
    unique case (mode)
      MODE_D4:  o = s << 2;
      MODE_D5:  o = (s << 2) + s;
      MODE_D10: o = (s << 3) + (s << 1);
      default:  o = (s << 3) + (s << 1) + s;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

### rtl/cbp_front.sv
// front end: takes coefficients, assembles packed groups, pushes full groups to the queue
`default_nettype none
module cbp_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [cbp_pkg::COEF_W-1:0]  coef_i,
  input  wire logic                        last_i,
  input  wire cbp_pkg::fifo_status_t       fifo_status_i,
  output cbp_pkg::push_t                   push_o
);

  cbp_pkg::width_mode_e                mode_q;
  logic [cbp_pkg::FILL_W-1:0]          fill_q, fill_d;
  logic [cbp_pkg::GROUP_BITS-1:0]      packed_q, packed_d;
  logic [cbp_pkg::OFF_W-1:0]           offset;
  logic                                accept;
  logic                                slot_last;

  assign in_ready_o = !fifo_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign offset     = cbp_pkg::slot_offset(mode_q, fill_q);
  assign slot_last  = (fill_q == cbp_pkg::last_slot(mode_q));

  always_comb begin
    packed_d = packed_q;
    packed_d[offset +: cbp_pkg::COEF_W] = coef_i & cbp_pkg::coef_mask(mode_q);
    if (slot_last || last_i) begin
      fill_d = '0;
    end else begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cbp_pkg::MODE_RESET;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cbp_pkg::width_mode_e'(cfg_wdata_i);
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      packed_q <= packed_d;
    end
  end

  assign push_o.valid      = accept && slot_last;
  assign push_o.grp.bits   = packed_d;
  assign push_o.grp.nbytes = cbp_pkg::burst_len(mode_q);

endmodule
`default_nettype wire

### rtl/cbp_fifo.sv
// short register queue of packed groups between front and back
`default_nettype none
module cbp_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cbp_pkg::push_t         push_i,
  input  wire logic                   pop_i,
  output cbp_pkg::group_t             head_o,
  output cbp_pkg::fifo_status_t       status_o
);

  cbp_pkg::group_t                    mem_q [cbp_pkg::FIFO_DEPTH];
  logic [cbp_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cbp_pkg::FIFO_CNT_W-1:0]     cnt_q;
  logic                               do_push, do_pop;

  assign status_o.full  = (cnt_q == cbp_pkg::FIFO_CNT_W'(cbp_pkg::FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i.valid && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.grp;
    end
  end

endmodule
`default_nettype wire

### rtl/cbp_back.sv
// back end: serializes one packed group per burst onto the byte stream
`default_nettype none
module cbp_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cbp_pkg::group_t         head_i,
  input  wire cbp_pkg::fifo_status_t   fifo_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         out_last_o
);

  logic [cbp_pkg::GROUP_BITS-1:0]  shift_q;
  logic [cbp_pkg::NBYTES_W-1:0]    cnt_q;
  logic                            busy_q;
  logic                            last_byte;
  logic                            out_fire;

  assign last_byte   = (cnt_q == cbp_pkg::NBYTES_W'(1));
  assign out_fire    = busy_q && out_ready_i;
  assign pop_o       = !fifo_status_i.empty && (!busy_q || (out_fire && last_byte));
  assign out_valid_o = busy_q;
  assign out_byte_o  = shift_q[7:0];
  assign out_last_o  = last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= head_i.nbytes;
    end else if (out_fire) begin
      if (last_byte) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      shift_q <= head_i.bits;
    end else if (out_fire) begin
      shift_q <= shift_q >> 8;
    end
  end

endmodule
`default_nettype wire

### rtl/coefficient_bit_packer_core.sv
// top level of the coefficient bit packer (ML-KEM ByteEncode_d)
//
// input stream: one coefficient per request; tdata[10:0] holds the coefficient,
// tlast marks the last coefficient of a polynomial and drops an unfinished group.
// output stream: one packed byte per request, LSB-first bitstream; tlast is high
// on the last byte of each group burst (4, 5, 5 or 11 bytes for d = 4, 5, 10, 11).
// cfg_we_i writes width_mode (0:d=4, 1:d=5, 2:d=10, 3:d=11) and clears the
// partial group; write only while idle.
// the front takes one coefficient per cycle into a group register while the queue
// is not full; a full group goes through a two-entry queue to the back, which sends
// one byte per cycle while the receiver is ready. with the back end idle, a completed
// group is written into the queue and then into the back's shift register, which
// presents its first byte. the single byte port sets the sustained rate at d=11 and
// d=10; at d=4 and d=5 the input side sets it at one coefficient per cycle.
// when the receiver stalls, the queue fills and s_axis_tready drops.
// reset: width_mode returns to 3 (d=11), group count and queue are cleared.
`default_nettype none
module coefficient_bit_packer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [10:0] coefficient, [15:11] zero
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] packed_byte
  output logic             m_axis_tlast
);

  cbp_pkg::push_t        push;
  cbp_pkg::group_t       head;
  cbp_pkg::fifo_status_t fifo_status;
  logic                  pop;

  cbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .coef_i        (s_axis_tdata[cbp_pkg::COEF_W-1:0]),
    .last_i        (s_axis_tlast),
    .fifo_status_i (fifo_status),
    .push_o        (push)
  );

  cbp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (fifo_status)
  );

  cbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !fifo_status.full)
    else $error("group pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("group popped from empty queue");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (s_axis_tvalid && s_axis_tready))
    else $error("group pushed without an input request");

  a_pop_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid)
    else $error("popped group not presented on output");
`endif

endmodule
`default_nettype wire

### sim/testbench.sv
// self-checking testbench for coefficient_bit_packer_core: directed table, then random streams
`default_nettype none
module testbench;

  typedef enum logic {ROW_COEF, ROW_MODE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [10:0] value;
    logic        eop;
    logic        typed;
    logic [7:0]  typed_byte;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       grp_last;
  } packed_byte_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_ROWS = 29;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_tdata = 16'd0;
  logic        s_tlast = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  // predictor state
  cbp_pkg::width_mode_e cur_mode = cbp_pkg::MODE_D11;
  logic [10:0]  coef_store [cbp_pkg::MAX_GROUP];
  int           fill_cnt = 0;
  logic [7:0]   burst_bytes [11];
  int           burst_count;
  packed_byte_t pending_bytes [$];

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF}, '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF},
    '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF}, '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF},
    '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF}, '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF},
    '{ROW_COEF, 11'h7FF, 1'b0, 1'b1, 8'hFF}, '{ROW_COEF, 11'h7FF, 1'b1, 1'b1, 8'hFF},
    '{ROW_MODE, 11'(cbp_pkg::MODE_D4), 1'b0, 1'b0, 8'h00},
    '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00}, '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00},
    '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00}, '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00},
    '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00}, '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00},
    '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00}, '{ROW_COEF, 11'h7F0, 1'b0, 1'b1, 8'h00},
    '{ROW_MODE, 11'(cbp_pkg::MODE_D5), 1'b0, 1'b0, 8'h00},
    '{ROW_COEF, 11'h01F, 1'b0, 1'b0, 8'h00}, '{ROW_COEF, 11'h7E0, 1'b0, 1'b0, 8'h00},
    '{ROW_COEF, 11'h015, 1'b1, 1'b0, 8'h00},
    '{ROW_MODE, 11'(cbp_pkg::MODE_D10), 1'b0, 1'b0, 8'h00},
    '{ROW_COEF, 11'h3FF, 1'b0, 1'b0, 8'h00}, '{ROW_COEF, 11'h400, 1'b0, 1'b0, 8'h00},
    '{ROW_MODE, 11'(cbp_pkg::MODE_D10), 1'b0, 1'b0, 8'h00},
    '{ROW_COEF, 11'h155, 1'b0, 1'b0, 8'h00}, '{ROW_COEF, 11'h2AA, 1'b0, 1'b0, 8'h00},
    '{ROW_COEF, 11'h7FF, 1'b0, 1'b0, 8'h00}, '{ROW_COEF, 11'h001, 1'b0, 1'b0, 8'h00}
  };

  coefficient_bit_packer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    packed_byte_t exp_b;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected packed_byte %h with no request pending", m_tdata);
        error_count++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (m_tdata !== exp_b.pbyte) begin
          $error("packed_byte mismatch: expected %h, actual %h", exp_b.pbyte, m_tdata);
          error_count++;
        end
        if (m_tlast !== exp_b.grp_last) begin
          $error("group_done mismatch: expected %b, actual %b", exp_b.grp_last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // packs one accepted coefficient into the group; fills burst_bytes when a group closes
  task automatic pack_coefficient(input logic [10:0] coef, input logic eop);
    int d;
    int grp;
    logic [87:0] stream;
    d = (cur_mode == cbp_pkg::MODE_D4) ? 4 : (cur_mode == cbp_pkg::MODE_D5) ? 5 :
        (cur_mode == cbp_pkg::MODE_D10) ? 10 : 11;
    grp = (cur_mode == cbp_pkg::MODE_D10) ? 4 : 8;
    burst_count = 0;
    coef_store[fill_cnt] = coef & 11'((1 << d) - 1);
    fill_cnt++;
    if (fill_cnt >= grp) begin
      stream = '0;
      for (int i = 0; i < grp; i++) begin
        for (int j = 0; j < d; j++) begin
          stream[i * d + j] = coef_store[i][j];
        end
      end
      burst_count = grp * d / 8;
      for (int b = 0; b < burst_count; b++) begin
        burst_bytes[b] = stream[8 * b +: 8];
      end
      fill_cnt = 0;
    end
    if (eop) begin
      fill_cnt = 0;
    end
  endtask

  task automatic send_coefficient(input logic [10:0] coef, input logic eop,
                                  input logic typed, input logic [7:0] typed_byte);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      s_tdata <= {5'd0, 11'($urandom)};
      s_tlast <= 1'($urandom);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_tdata <= {5'd0, coef};
    s_tlast <= eop;
    do begin
      @(posedge clk_i);
    end while (!s_ready);
    pack_coefficient(coef, eop);
    for (int b = 0; b < burst_count; b++) begin
      pending_bytes.push_back('{typed ? typed_byte : burst_bytes[b], b == burst_count - 1});
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_width_mode(input cbp_pkg::width_mode_e mode);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_mode = mode;
    fill_cnt = 0;
  endtask

  initial begin
    int pick;
    logic [10:0] coef;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_MODE) begin
        set_width_mode(cbp_pkg::width_mode_e'(directed_rows[r].value[1:0]));
      end else begin
        send_coefficient(directed_rows[r].value, directed_rows[r].eop,
                         directed_rows[r].typed, directed_rows[r].typed_byte);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      for (int k = 0; k < 4; k++) begin
        set_width_mode(cbp_pkg::width_mode_e'((p + k) % 4));
        for (int i = 0; i < 12; i++) begin
          pick = $urandom_range(9);
          coef = (pick == 0) ? 11'h000 : (pick == 1) ? 11'h7FF : 11'($urandom_range(2047));
          send_coefficient(coef, $urandom_range(15) == 0, 1'b0, 8'h00);
          if (p == 2 && k == 1 && i == 5) begin
            hold_until_drained();
          end
        end
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
